>>> hdl/qrs_pkg.sv
// Shared definitions for the quadratic root solver.
// Holds the default word formats and the result status codes; no dependencies.
`default_nettype none

package qrs_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NO_REAL = 2'd1,
    ST_A_ZERO  = 2'd2
  } status_t;

endpackage

`default_nettype wire

>>> hdl/qrs_sqrt_cell.sv
// One bit step of the pipelined integer square root.
// Stand-alone cell; chained by quadratic_root_solver, no package use.
`default_nettype none

module qrs_sqrt_cell #(
  parameter int SW = 33
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [2*SW-1:0]   rad_in,
  input  wire logic [SW+1:0]     rem_in,
  input  wire logic [SW-1:0]     root_in,
  output logic      [2*SW-1:0]   rad_out,
  output logic      [SW+1:0]     rem_out,
  output logic      [SW-1:0]     root_out
);

  logic [SW+1:0] rem_sh;
  logic [SW+1:0] trial;
  logic          fits;

  // Bring down the next two radicand bits and try a one in this root bit.
  assign rem_sh = {rem_in[SW-1:0], rad_in[2*SW-1 -: 2]};
  assign trial  = {root_in, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[2*SW-3:0], 2'b00};
      rem_out  <= fits ? (rem_sh - trial) : rem_sh;
      root_out <= {root_in[SW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> hdl/qrs_div_cell.sv
// One bit step of the pipelined restoring divider.
// Stand-alone cell; chained by quadratic_root_solver, no package use.
`default_nettype none

module qrs_div_cell #(
  parameter int NW = 52,
  parameter int DVW = 34
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [NW-1:0]   num_in,
  input  wire logic [DVW-1:0]  rem_in,
  input  wire logic [NW-1:0]   quo_in,
  input  wire logic [DVW-1:0]  den_in,
  output logic      [NW-1:0]   num_out,
  output logic      [DVW-1:0]  rem_out,
  output logic      [NW-1:0]   quo_out,
  output logic      [DVW-1:0]  den_out
);

  logic [DVW-1:0] rem_sh;
  logic           fits;

  // The remainder stays below the divisor, so its top bit is always clear.
  assign rem_sh = {rem_in[DVW-2:0], num_in[NW-1]};
  assign fits   = (rem_sh >= den_in);

  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= {num_in[NW-2:0], 1'b0};
      rem_out <= fits ? (rem_sh - den_in) : rem_sh;
      quo_out <= {quo_in[NW-2:0], fits};
      den_out <= den_in;
    end
  end

endmodule

`default_nettype wire

>>> hdl/quadratic_root_solver.sv
// Top level of the quadratic root solver: stream ports, discriminant, root assembly.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.
`default_nettype none

// Solves a*x^2 + b*x + c = 0 for signed fixed-point coefficients (WORD_BITS wide,
// FRAC_BITS fraction bits). Each request carries coef_a, coef_b and coef_c and
// yields exactly one result: the two real roots in the same format, smaller
// first, rounded to nearest with ties away from zero and clamped to the word
// range (the saturated flag tells when), or a status of no real roots or of a
// zero leading coefficient, in which case both roots and the flag are zero.
// The block is a fully pipelined row of cells: two multipliers, the exact
// discriminant, WORD_BITS+1 square root cells, the numerators, and two rows of
// WORD_BITS+FRAC_BITS+4 divider cells working side by side. While the output
// is not stalled it takes one request per clock and delivers one result per
// clock; the latency from acceptance to a valid result is set by the length
// of the square root and divider rows. When the output is stalled the whole
// row holds, and a one-entry input skid register still takes one more request.

module quadratic_root_solver #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // From bit 0 up: coef_a, coef_b, coef_c, zero padding to whole bytes.
  input  wire logic [((3*WORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // From bit 0 up: root_low, root_high, zero padding to whole bytes.
  output logic      [((2*WORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // From bit 0 up: status (2 bits), saturated.
  output logic      [2:0]                            m_axis_tuser
);

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int PW     = 2 * W;          // product width
  localparam int DW     = 2 * W + 1;      // discriminant width
  localparam int SW     = W + 1;          // square root width
  localparam int NSW    = W + 3;          // signed numerator width
  localparam int MW     = W + 2;          // numerator magnitude width
  localparam int DVW    = W + 2;          // divisor width (4*|a|)
  localparam int NW     = W + F + 4;      // dividend and quotient width
  localparam int IN_TW  = ((3 * W + 7) / 8) * 8;
  localparam int OUT_TW = ((2 * W + 7) / 8) * 8;

  // Pipeline advances whenever the output register can take a new value.
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;

  // ---------------------------------------------------------------------------
  // Input skid register: a request arriving during a stall is parked here.
  // ---------------------------------------------------------------------------
  logic             skid_v;
  logic [IN_TW-1:0] skid_data;
  logic             in_acc;
  logic             in_v;
  logic [IN_TW-1:0] in_data;

  assign s_axis_tready = !skid_v;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_v          = skid_v || in_acc;
  assign in_data       = skid_v ? skid_data : s_axis_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (en) begin
      skid_v <= 1'b0;
    end else if (in_acc) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_acc) begin
      skid_data <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: magnitudes and the two products b*b and a*c.
  // ---------------------------------------------------------------------------
  logic [W-1:0]  ia, ib, ic;
  logic [W-1:0]  a_mag, b_mag, c_mag;
  logic [PW-1:0] bb_c, ac_c;

  assign ia    = in_data[W-1:0];
  assign ib    = in_data[2*W-1:W];
  assign ic    = in_data[3*W-1:2*W];
  assign a_mag = ia[W-1] ? (~ia + 1'b1) : ia;
  assign b_mag = ib[W-1] ? (~ib + 1'b1) : ib;
  assign c_mag = ic[W-1] ? (~ic + 1'b1) : ic;
  assign bb_c  = b_mag * b_mag;
  assign ac_c  = a_mag * c_mag;

  logic                p1_v;
  qrs_pkg::status_t    p1_st;
  logic [PW-1:0]       p1_bb, p1_ac;
  logic                p1_opp;
  logic [W-1:0]        p1_b, p1_amag;
  logic                p1_aneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (en) begin
      p1_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_st   <= (ia == '0) ? qrs_pkg::ST_A_ZERO : qrs_pkg::ST_FOUND;
      p1_bb   <= bb_c;
      p1_ac   <= ac_c;
      // Opposite signs of a and c make -4ac positive.
      p1_opp  <= (ic != '0) && (ia[W-1] != ic[W-1]);
      p1_b    <= ib;
      p1_amag <= a_mag;
      p1_aneg <= ia[W-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: discriminant b*b - 4ac with one adder, sign taken from the top bit.
  // ---------------------------------------------------------------------------
  logic [PW+1:0] ac4, ac_op, disc_c;
  logic          disc_neg;

  assign ac4      = {p1_ac, 2'b00};
  assign ac_op    = p1_opp ? ac4 : ~ac4;
  assign disc_c   = {2'b00, p1_bb} + ac_op + {{(PW+1){1'b0}}, !p1_opp};
  assign disc_neg = !p1_opp && disc_c[PW+1];

  // Side data that travels beside the square root cells; entry 0 is stage 2.
  logic             sq_v    [0:SW];
  qrs_pkg::status_t sq_st   [0:SW];
  logic [W-1:0]     sq_b    [0:SW];
  logic [W-1:0]     sq_amag [0:SW];
  logic             sq_aneg [0:SW];

  logic [2*SW-1:0]  sq_rad  [0:SW];
  logic [SW+1:0]    sq_rem  [0:SW];
  logic [SW-1:0]    sq_root [0:SW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (p1_st == qrs_pkg::ST_FOUND && disc_neg) begin
        sq_st[0] <= qrs_pkg::ST_NO_REAL;
      end else begin
        sq_st[0] <= p1_st;
      end
      sq_b[0]    <= p1_b;
      sq_amag[0] <= p1_amag;
      sq_aneg[0] <= p1_aneg;
      sq_rad[0]  <= (2*SW)'(disc_c[DW-1:0]);
    end
  end

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  // ---------------------------------------------------------------------------
  // Square root row: one result bit per cell.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW)) u_cell (
      .clk      (clk),
      .en       (en),
      .rad_in   (sq_rad[k]),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .rad_out  (sq_rad[k+1]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_st[k+1]   <= sq_st[k];
        sq_b[k+1]    <= sq_b[k];
        sq_amag[k+1] <= sq_amag[k];
        sq_aneg[k+1] <= sq_aneg[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: numerators -b + S and -b - S, exact in NSW bits.
  // ---------------------------------------------------------------------------
  logic signed [NSW-1:0] nb, s_ext;

  assign nb    = -$signed({{3{sq_b[SW][W-1]}}, sq_b[SW]});
  assign s_ext = $signed({2'b00, sq_root[SW]});

  logic                  p3_v;
  qrs_pkg::status_t      p3_st;
  logic signed [NSW-1:0] p3_n1, p3_n2;
  logic [W-1:0]          p3_amag;
  logic                  p3_aneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else if (en) begin
      p3_v <= sq_v[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_st   <= sq_st[SW];
      p3_n1   <= nb + s_ext;
      p3_n2   <= nb - s_ext;
      p3_amag <= sq_amag[SW];
      p3_aneg <= sq_aneg[SW];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: dividends |N|*2^(F+1) + 2|a| and divisor 4|a|, which gives the
  // quotient of |N|*2^F / (2|a|) rounded half away from zero.
  // ---------------------------------------------------------------------------
  logic [NSW-1:0] n1_abs, n2_abs;
  logic [MW-1:0]  m1, m2;
  logic [NW-1:0]  a2_ext;

  assign n1_abs = p3_n1[NSW-1] ? NSW'(-p3_n1) : NSW'(p3_n1);
  assign n2_abs = p3_n2[NSW-1] ? NSW'(-p3_n2) : NSW'(p3_n2);
  assign m1     = n1_abs[MW-1:0];
  assign m2     = n2_abs[MW-1:0];
  assign a2_ext = NW'({p3_amag, 1'b0});

  // Side data that travels beside the divider cells; entry 0 is stage 4.
  logic             dv_v    [0:NW];
  qrs_pkg::status_t dv_st   [0:NW];
  logic             dv_neg1 [0:NW];
  logic             dv_neg2 [0:NW];

  logic [NW-1:0]    dv_num1 [0:NW];
  logic [NW-1:0]    dv_num2 [0:NW];
  logic [DVW-1:0]   dv_rem1 [0:NW];
  logic [DVW-1:0]   dv_rem2 [0:NW];
  logic [NW-1:0]    dv_quo1 [0:NW];
  logic [NW-1:0]    dv_quo2 [0:NW];
  logic [DVW-1:0]   dv_den1 [0:NW];
  logic [DVW-1:0]   dv_den2 [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_st[0]   <= p3_st;
      dv_neg1[0] <= p3_n1[NSW-1] ^ p3_aneg;
      dv_neg2[0] <= p3_n2[NSW-1] ^ p3_aneg;
      dv_num1[0] <= NW'({m1, {(F+1){1'b0}}}) + a2_ext;
      dv_num2[0] <= NW'({m2, {(F+1){1'b0}}}) + a2_ext;
      dv_den1[0] <= {p3_amag, 2'b00};
      dv_den2[0] <= {p3_amag, 2'b00};
    end
  end

  assign dv_rem1[0] = '0;
  assign dv_rem2[0] = '0;
  assign dv_quo1[0] = '0;
  assign dv_quo2[0] = '0;

  // ---------------------------------------------------------------------------
  // Divider rows: one quotient bit per cell, one row for each root.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < NW; k++) begin : g_div
    qrs_div_cell #(.NW(NW), .DVW(DVW)) u_cell1 (
      .clk     (clk),
      .en      (en),
      .num_in  (dv_num1[k]),
      .rem_in  (dv_rem1[k]),
      .quo_in  (dv_quo1[k]),
      .den_in  (dv_den1[k]),
      .num_out (dv_num1[k+1]),
      .rem_out (dv_rem1[k+1]),
      .quo_out (dv_quo1[k+1]),
      .den_out (dv_den1[k+1])
    );

    qrs_div_cell #(.NW(NW), .DVW(DVW)) u_cell2 (
      .clk     (clk),
      .en      (en),
      .num_in  (dv_num2[k]),
      .rem_in  (dv_rem2[k]),
      .quo_in  (dv_quo2[k]),
      .den_in  (dv_den2[k]),
      .num_out (dv_num2[k+1]),
      .rem_out (dv_rem2[k+1]),
      .quo_out (dv_quo2[k+1]),
      .den_out (dv_den2[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_st[k+1]   <= dv_st[k];
        dv_neg1[k+1] <= dv_neg1[k];
        dv_neg2[k+1] <= dv_neg2[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final stage: sign, clamp to the word range, order the roots.
  // A negative root may reach -2^(W-1); a positive one stops at 2^(W-1)-1.
  // ---------------------------------------------------------------------------
  logic [NW-1:0]        lim1, lim2, q1, q2, mq1, mq2;
  logic                 sat1, sat2;
  logic signed [W-1:0]  r1, r2, r_lo, r_hi;

  assign q1   = dv_quo1[NW];
  assign q2   = dv_quo2[NW];
  assign lim1 = (NW'(1) << (W - 1)) - NW'(!dv_neg1[NW]);
  assign lim2 = (NW'(1) << (W - 1)) - NW'(!dv_neg2[NW]);
  assign sat1 = (q1 > lim1);
  assign sat2 = (q2 > lim2);
  assign mq1  = sat1 ? lim1 : q1;
  assign mq2  = sat2 ? lim2 : q2;
  assign r1   = dv_neg1[NW] ? $signed(~mq1[W-1:0] + 1'b1) : $signed(mq1[W-1:0]);
  assign r2   = dv_neg2[NW] ? $signed(~mq2[W-1:0] + 1'b1) : $signed(mq2[W-1:0]);
  assign r_lo = (r1 < r2) ? r1 : r2;
  assign r_hi = (r1 < r2) ? r2 : r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_st[NW] == qrs_pkg::ST_FOUND) begin
        m_axis_tdata <= OUT_TW'({r_hi, r_lo});
        m_axis_tuser <= {sat1 || sat2, dv_st[NW]};
      end else begin
        m_axis_tdata <= '0;
        m_axis_tuser <= {1'b0, dv_st[NW]};
      end
    end
  end

endmodule

`default_nettype wire
